FILE: hw/rtl/srr_pkg.sv
// Shared widths, codes and types for the selective-repeat receiver.
`timescale 1ns / 1ps
package srr_pkg;

    localparam int WINDOW_DEF      = 24;
    localparam int MAX_PAYLOAD_DEF = 1281;

    localparam int FUNC_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int SEQ_W   = 16;
    localparam int LEN_W   = 11;
    localparam int CRC_W   = 32;
    localparam int KIND_W  = 3;
    localparam int WIDE_W  = 32;
    localparam int SLOT_OUT_W = 5;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 88;

    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_HEADER  = 2'd0,
        FUNC_PAYLOAD = 2'd1,
        FUNC_END     = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_CORRUPT   = 3'd0,
        KIND_ACCEPTED  = 3'd1,
        KIND_DELIVERED = 3'd2,
        KIND_IGNORED   = 3'd3,
        KIND_ACK       = 3'd4
    } kind_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_RD    = 6'b000100,
        ST_DLV   = 6'b001000,
        ST_ACK1  = 6'b010000,
        ST_ACK2  = 6'b100000
    } state_t;

    typedef struct packed {
        logic             clear;
        logic             update;
        logic [BYTE_W-1:0] data;
    } crc_ctl_t;

endpackage

FILE: hw/rtl/selective_repeat_receiver.sv
// Selective-repeat receiver top level: window control, length RAM and result register.
// Header, payload-byte and unused-code words are taken whenever the receiver is idle,
// with results never produced for them. After an end word the input is held through the
// check state when the packet is corrupt and through the check and two ack states
// otherwise; a packet at the window base adds a read state for the final slot lookup plus
// a read and a deliver state per packet delivered, as the controller reads each stored
// length from the slot RAM, whose read is registered; a stalled result output adds its
// wait. Received flags reset at once, so no clearing pass follows reset. After the
// completing ack every word is taken and dropped.
`timescale 1ns / 1ps
module selective_repeat_receiver
    import srr_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // data_byte[7:0], seq_num[23:8], pkt_len[34:24], checksum[66:35], zeros
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [FUNC_W-1:0]     s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // seq_out[31:0], slot[36:32], length_out[47:37], ack_value[79:48], done_res[80], zeros
    output logic [OUT_DATA_W-1:0] m_tdata,
    // kind[2:0]
    output logic [KIND_W-1:0]     m_tuser,
    output logic                  m_tlast
);

    localparam int SLOT_W = $clog2(WINDOW);

    state_t              state_reg, state_next;
    logic [WIDE_W-1:0]   base_reg, base_next;
    logic [SLOT_W-1:0]   base_slot_reg, base_slot_next;
    logic [WINDOW-1:0]   flags_reg, flags_next;
    logic                finished_reg, finished_next;
    logic [SEQ_W-1:0]    cur_seq_reg;
    logic [LEN_W-1:0]    cur_len_reg;
    logic [CRC_W-1:0]    cur_sum_reg;
    logic                cur_last_reg;

    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic [WIDE_W-1:0]   out_seq_reg, out_seq_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [LEN_W-1:0]    out_len_reg, out_len_next;
    logic [WIDE_W-1:0]   out_ack_reg, out_ack_next;
    logic                out_done_reg, out_done_next;
    logic                out_last_reg, out_last_next;

    crc_ctl_t            crc_ctl;
    logic [CRC_W-1:0]    crc;
    logic                ram_we, ram_re;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [LEN_W-1:0]    ram_rdata;

    logic                in_acc;
    func_t               func;
    logic [WIDE_W-1:0]   seq_wide, ack;
    logic [WIDE_W:0]     diff;
    logic                in_window, corrupt, done;
    logic [SLOT_W:0]     slot_sum;
    logic [SLOT_W-1:0]   slot;
    logic                can_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign func     = func_t'(s_tuser);
    assign can_load = !out_valid_reg || m_tready;

    assign seq_wide  = {{(WIDE_W-SEQ_W){1'b0}}, cur_seq_reg};
    assign diff      = {1'b0, seq_wide} - {1'b0, base_reg};
    assign in_window = !diff[WIDE_W] && (diff[WIDE_W-1:0] < WIDE_W'(WINDOW));
    assign slot_sum  = {1'b0, base_slot_reg} + {1'b0, diff[SLOT_W-1:0]};
    assign slot      = (slot_sum >= (SLOT_W+1)'(WINDOW))
                       ? SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW)) : slot_sum[SLOT_W-1:0];
    assign corrupt   = (~crc != cur_sum_reg) || (cur_len_reg > LEN_W'(MAX_PAYLOAD));
    assign ack       = base_reg - WIDE_W'(1);
    assign done      = (cur_last_reg && (seq_wide == ack))
                       || ((cur_len_reg == '0) && cur_last_reg);

    assign crc_ctl.clear  = in_acc && !finished_reg && (func == FUNC_HEADER);
    assign crc_ctl.update = in_acc && !finished_reg && (func == FUNC_PAYLOAD);
    assign crc_ctl.data   = s_tdata[7:0];

    srr_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .crc   (crc)
    );

    srr_ram #(
        .WIDTH (LEN_W),
        .DEPTH (WINDOW)
    ) u_len_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (cur_len_reg),
        .rd_en   (ram_re),
        .rd_addr (base_slot_reg),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        base_slot_next = base_slot_reg;
        flags_next     = flags_reg;
        finished_next  = finished_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_seq_next   = out_seq_reg;
        out_slot_next  = out_slot_reg;
        out_len_next   = out_len_reg;
        out_ack_next   = out_ack_reg;
        out_done_next  = out_done_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot;
        ram_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && !finished_reg && (func == FUNC_END))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (can_load)
                begin
                    out_seq_next  = seq_wide;
                    out_slot_next = '0;
                    out_len_next  = cur_len_reg;
                    out_ack_next  = '0;
                    out_done_next = 1'b0;
                    out_last_next = 1'b0;
                    if (corrupt)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_CORRUPT;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else if (in_window)
                    begin
                        flags_next[slot] = 1'b1;
                        ram_we           = 1'b1;
                        if (diff[WIDE_W-1:0] != '0)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_ACCEPTED;
                            out_slot_next  = slot;
                            state_next     = ST_ACK1;
                        end
                        else
                        begin
                            state_next = ST_RD;
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_IGNORED;
                        state_next     = ST_ACK1;
                    end
                end
            end
            ST_RD:
            begin
                if (flags_reg[base_slot_reg])
                begin
                    ram_re     = 1'b1;
                    state_next = ST_DLV;
                end
                else
                begin
                    state_next = ST_ACK1;
                end
            end
            ST_DLV:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_DELIVERED;
                    out_seq_next   = base_reg;
                    out_slot_next  = base_slot_reg;
                    out_len_next   = ram_rdata;
                    out_ack_next   = '0;
                    out_done_next  = 1'b0;
                    out_last_next  = 1'b0;
                    flags_next[base_slot_reg] = 1'b0;
                    base_next      = base_reg + WIDE_W'(1);
                    base_slot_next = (base_slot_reg == SLOT_W'(WINDOW - 1))
                                     ? '0 : base_slot_reg + SLOT_W'(1);
                    state_next     = ST_RD;
                end
            end
            ST_ACK1:
            begin
                if (seq_wide > ack)
                begin
                    state_next = ST_ACK2;
                end
                else if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ACK;
                    out_seq_next   = seq_wide;
                    out_slot_next  = '0;
                    out_len_next   = '0;
                    out_ack_next   = ack;
                    out_done_next  = 1'b0;
                    out_last_next  = 1'b0;
                    state_next     = ST_ACK2;
                end
            end
            ST_ACK2:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ACK;
                    out_seq_next   = seq_wide;
                    out_slot_next  = '0;
                    out_len_next   = '0;
                    out_ack_next   = ack;
                    out_done_next  = done;
                    out_last_next  = 1'b1;
                    finished_next  = done;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= '0;
            base_slot_reg <= '0;
            flags_reg     <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            base_slot_reg <= base_slot_next;
            flags_reg     <= flags_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        // latch packet fields on a header word
        if (in_acc && !finished_reg && (func == FUNC_HEADER))
        begin
            cur_seq_reg  <= s_tdata[23:8];
            cur_len_reg  <= s_tdata[34:24];
            cur_sum_reg  <= s_tdata[66:35];
            cur_last_reg <= s_tlast;
        end
        out_kind_reg <= out_kind_next;
        out_seq_reg  <= out_seq_next;
        out_slot_reg <= out_slot_next;
        out_len_reg  <= out_len_next;
        out_ack_reg  <= out_ack_next;
        out_done_reg <= out_done_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_DATA_W-81){1'b0}}, out_done_reg, out_ack_reg, out_len_reg,
                       SLOT_OUT_W'(out_slot_reg), out_seq_reg};

endmodule

FILE: hw/rtl/srr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module srr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/srr_crc.sv
// CRC-32 register, reflected, one byte per cycle while update is asserted.
`timescale 1ns / 1ps
module srr_crc
    import srr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  crc_ctl_t         ctl,
    output logic [CRC_W-1:0] crc
);

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;

    always_comb
    begin
        logic [CRC_W-1:0] c;
        c = crc_reg ^ {{(CRC_W-BYTE_W){1'b0}}, ctl.data};
        for (int b = 0; b < 8; b++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
        end
        if (ctl.clear)
        begin
            crc_next = CRC_INIT;
        end
        else if (ctl.update)
        begin
            crc_next = c;
        end
        else
        begin
            crc_next = crc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

FILE: verif/srr_checker.sv
// Scoreboard for the selective-repeat receiver: predicts results from accepted words and compares.
`timescale 1ns / 1ps
package srr_tb_pkg;

    import srr_pkg::*;

    // Advance a reflected CRC-32 by one byte.
    function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

module srr_checker
    import srr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [FUNC_W-1:0]     s_tuser,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [KIND_W-1:0]     m_tuser,
    input  logic                  m_tlast,
    output int                    errors,
    output int                    pending,
    output logic [31:0]           base_now,
    output int                    words_in,
    output int                    results_out,
    output int                    delivered
);

    typedef struct {
        kind_t       kind;
        logic [31:0] seq;
        logic [4:0]  slot;
        logic [10:0] len;
        logic [31:0] ack;
        logic        done;
        logic        last;
    } result_t;

    result_t     expected_q[$];
    logic [31:0] base;
    logic [31:0] crc;
    logic        got[WINDOW_DEF];
    logic [10:0] slot_len[WINDOW_DEF];
    logic [15:0] cur_seq;
    logic [10:0] cur_len;
    logic [31:0] cur_chk;
    logic        cur_last;
    logic        finished;

    assign pending  = expected_q.size();
    assign base_now = base;

    task automatic push_result(kind_t k, logic [31:0] sq, logic [4:0] sl, logic [10:0] ln,
                               logic [31:0] ak, logic dn, logic lst);
        result_t r;
        r.kind = k;
        r.seq  = sq;
        r.slot = sl;
        r.len  = ln;
        r.ack  = ak;
        r.done = dn;
        r.last = lst;
        expected_q.push_back(r);
    endtask

    // Close a packet: check the CRC, update the window and queue the acks.
    task automatic predict_packet_end();
        logic [31:0] sq;
        logic [31:0] ack;
        logic [4:0]  d;
        logic        dn;
        int          guard;
        sq = {16'd0, cur_seq};
        if (~crc != cur_chk || cur_len > MAX_PAYLOAD_DEF)
        begin
            push_result(KIND_CORRUPT, sq, 5'd0, cur_len, 32'd0, 1'b0, 1'b1);
            return;
        end
        if (sq >= base && {1'b0, sq} < {1'b0, base} + WINDOW_DEF)
        begin
            got[sq % WINDOW_DEF]      = 1'b1;
            slot_len[sq % WINDOW_DEF] = cur_len;
            if (sq > base)
            begin
                push_result(KIND_ACCEPTED, sq, 5'(sq % WINDOW_DEF), cur_len, 32'd0, 1'b0, 1'b0);
            end
            else
            begin
                guard = 0;
                while (guard < WINDOW_DEF)
                begin
                    d = 5'(base % WINDOW_DEF);
                    if (!got[d])
                        break;
                    push_result(KIND_DELIVERED, base, d, slot_len[d], 32'd0, 1'b0, 1'b0);
                    got[d] = 1'b0;
                    base++;
                    guard++;
                    delivered++;
                end
            end
        end
        else
        begin
            push_result(KIND_IGNORED, sq, 5'd0, cur_len, 32'd0, 1'b0, 1'b0);
        end
        ack = base - 32'd1;
        dn  = (cur_last && sq == ack) || (cur_len == 11'd0 && cur_last);
        if (sq <= ack)
            push_result(KIND_ACK, sq, 5'd0, 11'd0, ack, 1'b0, 1'b0);
        push_result(KIND_ACK, sq, 5'd0, 11'd0, ack, dn, 1'b1);
        if (dn)
            finished = 1'b1;
    endtask

    task automatic check_result();
        result_t e;
        logic    bad;
        if (expected_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("ERROR: unexpected result kind %0d data %h last %b",
                         m_tuser, m_tdata, m_tlast);
            return;
        end
        e   = expected_q.pop_front();
        bad = m_tuser != e.kind || m_tdata[31:0] != e.seq || m_tdata[36:32] != e.slot
              || m_tdata[47:37] != e.len || m_tdata[79:48] != e.ack
              || m_tdata[80] != e.done || m_tdata[87:81] != 7'd0 || m_tlast != e.last;
        if (bad)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("ERROR: expected kind %0d seq %0d slot %0d len %0d ack %h done %b last %b",
                         e.kind, e.seq, e.slot, e.len, e.ack, e.done, e.last);
                $display("       actual   kind %0d seq %0d slot %0d len %0d ack %h done %b last %b",
                         m_tuser, m_tdata[31:0], m_tdata[36:32], m_tdata[47:37],
                         m_tdata[79:48], m_tdata[80], m_tlast);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_q.delete();
            base        = 32'd0;
            crc         = CRC_INIT;
            cur_seq     = 16'd0;
            cur_len     = 11'd0;
            cur_chk     = 32'd0;
            cur_last    = 1'b0;
            finished    = 1'b0;
            errors      = 0;
            words_in    = 0;
            results_out = 0;
            delivered   = 0;
            for (int i = 0; i < WINDOW_DEF; i++)
            begin
                got[i]      = 1'b0;
                slot_len[i] = 11'd0;
            end
        end
        else
        begin
            // Take the result first: it can only stem from earlier words.
            if (m_tvalid && m_tready)
            begin
                results_out++;
                check_result();
            end
            if (s_tvalid && s_tready)
            begin
                words_in++;
                if (!finished)
                begin
                    case (func_t'(s_tuser))
                        FUNC_HEADER:
                        begin
                            cur_seq  = s_tdata[23:8];
                            cur_len  = s_tdata[34:24];
                            cur_chk  = s_tdata[66:35];
                            cur_last = s_tlast;
                            crc      = CRC_INIT;
                        end
                        FUNC_PAYLOAD: crc = srr_tb_pkg::crc_byte(crc, s_tdata[7:0]);
                        FUNC_END:     predict_packet_end();
                        default:      ;
                    endcase
                end
            end
        end
    end

endmodule

FILE: verif/tb_selective_repeat_receiver.sv
// Top of the selective-repeat receiver testbench: clock, reset, packet stimulus and verdict.
`timescale 1ns / 1ps
module tb_selective_repeat_receiver;

    import srr_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [FUNC_W-1:0]     s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;

    int          errors;
    int          pending;
    logic [31:0] base_now;
    int          words_in;
    int          results_out;
    int          delivered;
    int          phase;
    int          packets;

    selective_repeat_receiver dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    srr_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .errors      (errors),
        .pending     (pending),
        .base_now    (base_now),
        .words_in    (words_in),
        .results_out (results_out),
        .delivered   (delivered)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver stalls: heavy first, light next, none at the end.
    always @(negedge clk)
    begin
        if (phase == 0)
            m_tready <= $urandom_range(0, 99) >= 69;
        else if (phase == 1)
            m_tready <= $urandom_range(0, 99) >= 36;
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic put_word(func_t f, logic [7:0] b, logic [15:0] sq, logic [10:0] ln,
                            logic [31:0] ck, logic lf);
        int idle_pct;
        idle_pct = (phase == 0) ? 36 : (phase == 1) ? 69 : 0;
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = f;
        s_tlast  = lf;
        s_tdata  = {5'd0, ck, ln, sq, b};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Send header, nbytes payload words with stray unused-code words and an end word; spoil the checksum unless good.
    task automatic send_packet(logic [15:0] sq, logic [10:0] ln, int nbytes, bit good, logic lf);
        logic [7:0]  bytes[];
        logic [31:0] crc;
        logic [31:0] ck;
        bytes = new[nbytes];
        crc   = CRC_INIT;
        for (int i = 0; i < nbytes; i++)
        begin
            bytes[i] = 8'($urandom);
            crc      = srr_tb_pkg::crc_byte(crc, bytes[i]);
        end
        ck = good ? ~crc : ~crc ^ (32'($urandom) | 32'd1);
        put_word(FUNC_HEADER, 8'($urandom), sq, ln, ck, lf);
        for (int i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                put_word(FUNC_NONE, 8'($urandom), 16'($urandom), 11'($urandom), $urandom,
                         1'($urandom));
            put_word(FUNC_PAYLOAD, bytes[i], 16'($urandom), 11'($urandom), $urandom,
                     1'($urandom));
        end
        put_word(FUNC_END, 8'($urandom), 16'($urandom), 11'($urandom), $urandom, 1'($urandom));
        packets++;
    endtask

    // Send base+1 .. base+k-1 in shuffled order, then a corrupt and a good base to release the whole run.
    task automatic send_run(int k);
        logic [15:0] order[];
        logic [15:0] t;
        logic [15:0] b;
        int          j;
        b     = base_now[15:0];
        order = new[k - 1];
        for (int i = 0; i < k - 1; i++)
            order[i] = b + 16'(i + 1);
        for (int i = k - 2; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < k - 1; i++)
        begin
            int n;
            n = $urandom_range(0, 1);
            send_packet(order[i], 11'(n), n, 1'b1, 1'b0);
        end
        send_packet(b, 11'($urandom_range(0, 3)), 0, 1'b0, 1'b0);
        send_packet(b, 11'd2, 2, 1'b1, 1'b0);
    endtask

    initial
    begin
        int r;
        int n;
        phase    = 0;
        packets  = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = FUNC_HEADER;
        s_tlast  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: in-order, out-of-order, run release, window edges, bad packets.
        send_packet(16'd0, 11'd2, 2, 1'b1, 1'b0);
        send_packet(16'd2, 11'd1, 1, 1'b1, 1'b0);
        send_packet(16'd1, 11'd0, 0, 1'b1, 1'b0);
        send_packet(16'hFFFF, 11'd3, 3, 1'b1, 1'b1);
        send_packet(16'd3, 11'd1, 1, 1'b0, 1'b1);
        send_packet(16'd4, 11'h7FF, 0, 1'b1, 1'b0);
        send_packet(16'd3, 11'd1, 3, 1'b1, 1'b0);
        send_packet(16'd1, 11'd1, 1, 1'b1, 1'b0);
        send_packet(16'(base_now + 23), 11'd1, 1, 1'b1, 1'b0);
        send_packet(16'(base_now + 24), 11'd1, 1, 1'b1, 1'b1);
        send_packet(16'(base_now), 11'd1281, 2, 1'b1, 1'b0);
        send_packet(16'(base_now), 11'd1282, 0, 1'b1, 1'b0);
        send_run(24);

        for (int i = 0; i < 8; i++)
        begin
            phase = (i < 3) ? 0 : (i < 6) ? 1 : 2;
            r     = $urandom_range(0, 99);
            n     = $urandom_range(0, 3);
            if (r < 55)
                send_run($urandom_range(1, 3));
            else if (r < 70)
                send_packet(16'($urandom), 11'($urandom), n, 1'b0, 1'($urandom));
            else if (r < 80)
                send_packet(16'($urandom), 11'(n), n, 1'b1, 1'b0);
            else if (r < 90)
                send_packet(16'(base_now - $urandom_range(1, 3)), 11'(n), n, 1'b1, 1'b0);
            else
                send_packet(16'(base_now + $urandom_range(1, 23)), 11'(n),
                            $urandom_range(0, 3), 1'b1, 1'b0);
        end

        // Completing packet, then words that must be dropped.
        send_packet(16'(base_now), 11'd0, 0, 1'b1, 1'b1);
        send_packet(16'(base_now), 11'd1, 1, 1'b1, 1'b0);
        @(negedge clk);
        s_tvalid = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("Sent %0d packets in %0d words; checked %0d results, %0d delivered.",
                 packets, words_in, results_out, delivered);
        $display("Covered reordered runs up to a full window, corrupt and stale packets.");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/srr_pkg.sv
hw/rtl/srr_ram.sv
hw/rtl/srr_crc.sv
hw/rtl/selective_repeat_receiver.sv
verif/srr_checker.sv
verif/tb_selective_repeat_receiver.sv
